// ===== rtl/core/bsf_pkg.sv =====
package bsf_pkg;

   // Frame capacity default and register reset values
   localparam int MAX_BOXES_DEF = 64;
   localparam logic [15:0] SCORE_LIMIT_RST = 16'd45875;
   localparam logic [15:0] OVERLAP_LIMIT_RST = 16'd19661;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [15:0] left_edge;
      logic [15:0] top_edge;
      logic [15:0] right_edge;
      logic [15:0] bottom_edge;
      logic [15:0] box_score;
      logic        final_box;
   } req_type;

   typedef struct packed {
      logic [15:0] out_left;
      logic [15:0] out_top;
      logic [15:0] out_right;
      logic [15:0] out_bottom;
      logic [15:0] out_score;
      logic        box_valid;
      logic        overflowed;
      logic        last_result;
   } rsp_type;

   // One stored candidate
   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] score;
   } box_type;

   // Status back from the overlap unit
   typedef struct packed {
      logic done;
      logic hit;
   } iou_res_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RK_RDI,
      ST_RK_GETI,
      ST_RK_RDJ,
      ST_RK_CMP,
      ST_RK_WR,
      ST_SP_RDA,
      ST_SP_GETA,
      ST_SP_RDB,
      ST_SP_GETB,
      ST_SP_WAIT,
      ST_SP_EMIT,
      ST_EMPTY,
      ST_DONE
   } state_type;

   // Span of an edge pair, zero when reversed
   function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
      span16 = (hi > lo) ? hi - lo : 16'd0;
   endfunction

endpackage

// ===== rtl/core/bsf_iou.sv =====
module bsf_iou
   import bsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  box_type     box_a,
   input  box_type     box_b,
   input  logic [15:0] limit,
   output iou_res_type res
);

   // Step codes of the shared multiplier sequence
   localparam logic [2:0] STP_INTER = 3'd0;
   localparam logic [2:0] STP_AREA_A = 3'd1;
   localparam logic [2:0] STP_AREA_B = 3'd2;
   localparam logic [2:0] STP_UNION = 3'd3;
   localparam logic [2:0] STP_LO = 3'd4;
   localparam logic [2:0] STP_HI = 3'd5;
   localparam logic [2:0] STP_CMP = 3'd6;

   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   box_type     b_ff;
   logic [31:0] inter_ff, area_a_ff, area_b_ff;
   logic [32:0] uni_ff, part_lo_ff, part_hi_ff;
   logic [16:0] op_x;
   logic [15:0] op_y;
   logic [32:0] prod;
   logic [15:0] ix_lo, ix_hi, iy_lo, iy_hi;
   logic [48:0] lhs, rhs;

   // Intersection corners
   assign ix_lo = (box_a.left > b_ff.left) ? box_a.left : b_ff.left;
   assign iy_lo = (box_a.top > b_ff.top) ? box_a.top : b_ff.top;
   assign ix_hi = (box_a.right < b_ff.right) ? box_a.right : b_ff.right;
   assign iy_hi = (box_a.bottom < b_ff.bottom) ? box_a.bottom : b_ff.bottom;

   // Operand select for the one multiplier
   always_comb begin
      op_x = '0;
      op_y = '0;
      case (step_ff)
         STP_INTER: begin
            op_x = {1'b0, span16(ix_lo, ix_hi)};
            op_y = span16(iy_lo, iy_hi);
         end
         STP_AREA_A: begin
            op_x = {1'b0, span16(box_a.left, box_a.right)};
            op_y = span16(box_a.top, box_a.bottom);
         end
         STP_AREA_B: begin
            op_x = {1'b0, span16(b_ff.left, b_ff.right)};
            op_y = span16(b_ff.top, b_ff.bottom);
         end
         STP_LO: begin
            op_x = {1'b0, uni_ff[15:0]};
            op_y = limit;
         end
         STP_HI: begin
            op_x = uni_ff[32:16];
            op_y = limit;
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   assign prod = op_x * op_y;

   // inter * 65536 against limit * union
   assign lhs = {1'b0, inter_ff, 16'd0};
   assign rhs = {part_hi_ff[32:0], 16'd0} + {16'd0, part_lo_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STP_INTER;
      end else if (busy_ff) begin
         if (step_ff == STP_CMP) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   assign res.done = busy_ff && (step_ff == STP_CMP);
   assign res.hit = (uni_ff != '0) && (lhs > rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STP_INTER;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Product and partial result registers
   always_ff @(posedge clock) begin
      if (start) begin
         b_ff <= box_b;
      end
      if (busy_ff) begin
         case (step_ff)
            STP_INTER:  inter_ff <= prod[31:0];
            STP_AREA_A: area_a_ff <= prod[31:0];
            STP_AREA_B: area_b_ff <= prod[31:0];
            STP_UNION:  uni_ff <= {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};
            STP_LO:     part_lo_ff <= prod;
            STP_HI:     part_hi_ff <= prod;
            default:    ;
         endcase
      end
   end

endmodule

// ===== rtl/core/box_score_filter_nms.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_data (one candidate box)
// rsp      out        rsp_valid/rsp_ready    rsp_data (one surviving box)
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Loading takes one request per cycle. After the final request the block ranks
// n stored boxes with one score comparator, then runs greedy suppression with
// one shared multiplier.
// The request side is not ready from the final request until the frame ends.
// Reset is synchronous; box memories need no clearing, frame state clears at once.
// A stalled response waits in the output register; csr writes are always taken.
module box_score_filter_nms
   import bsf_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int IW = $clog2(MAX_BOXES);
   localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);
   localparam logic [CW-1:0] ONE = CW'(1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [IW-1:0]  pos_ff, pos_in;
   logic           any_ff, any_in;
   box_type        cur_ff, cur_in, a_ff, a_in;
   logic [MAX_BOXES-1:0] marks_ff, marks_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [15:0]    score_lim_ff, overlap_lim_ff;

   box_type        box_mem [MAX_BOXES];
   box_type        sort_mem [MAX_BOXES];
   box_type        bm_rdata_ff, sm_rdata_ff, new_box;
   logic [IW-1:0]  bm_raddr, sm_raddr;
   logic           bm_we, sm_we, iou_start, slot_free, keep;
   iou_res_type    iou_res;

   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign keep = req_data.box_score >= score_lim_ff;
   assign new_box = '{left: req_data.left_edge, top: req_data.top_edge,
                      right: req_data.right_edge, bottom: req_data.bottom_edge,
                      score: req_data.box_score};

   bsf_iou u_iou (
      .clock (clock),
      .reset (reset),
      .start (iou_start),
      .box_a (a_ff),
      .box_b (sm_rdata_ff),
      .limit (overlap_lim_ff),
      .res   (iou_res)
   );

   // Sequencer: load, rank, suppress, emit
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      i_in = i_ff;
      j_in = j_ff;
      pos_in = pos_ff;
      any_in = any_ff;
      cur_in = cur_ff;
      a_in = a_ff;
      marks_in = marks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      bm_we = 1'b0;
      sm_we = 1'b0;
      bm_raddr = '0;
      sm_raddr = '0;
      iou_start = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (keep && cnt_ff < CAP) begin
                  bm_we = 1'b1;
                  cnt_in = cnt_ff + ONE;
               end else if (keep) begin
                  ovf_in = 1'b1;
               end
               if (req_data.final_box) begin
                  i_in = '0;
                  state_in = (cnt_in == '0) ? ST_EMPTY : ST_RK_RDI;
               end
            end
         end
         ST_RK_RDI: begin
            bm_raddr = i_ff[IW-1:0];
            state_in = ST_RK_GETI;
         end
         ST_RK_GETI: begin
            cur_in = bm_rdata_ff;
            j_in = '0;
            pos_in = '0;
            state_in = ST_RK_RDJ;
         end
         ST_RK_RDJ: begin
            bm_raddr = j_ff[IW-1:0];
            state_in = ST_RK_CMP;
         end
         ST_RK_CMP: begin
            // count boxes ranked ahead: higher score, or equal and earlier
            if (bm_rdata_ff.score > cur_ff.score ||
                (bm_rdata_ff.score == cur_ff.score && j_ff < i_ff)) begin
               pos_in = pos_ff + IW'(1);
            end
            j_in = j_ff + ONE;
            state_in = (j_ff + ONE == cnt_ff) ? ST_RK_WR : ST_RK_RDJ;
         end
         ST_RK_WR: begin
            sm_we = 1'b1;
            if (i_ff + ONE == cnt_ff) begin
               i_in = '0;
               state_in = ST_SP_RDA;
            end else begin
               i_in = i_ff + ONE;
               state_in = ST_RK_RDI;
            end
         end
         ST_SP_RDA: begin
            if (i_ff == cnt_ff) begin
               state_in = ST_DONE;
            end else if (marks_ff[i_ff[IW-1:0]]) begin
               i_in = i_ff + ONE;
            end else begin
               sm_raddr = i_ff[IW-1:0];
               state_in = ST_SP_GETA;
            end
         end
         ST_SP_GETA: begin
            a_in = sm_rdata_ff;
            j_in = i_ff + ONE;
            any_in = 1'b0;
            state_in = ST_SP_RDB;
         end
         ST_SP_RDB: begin
            if (j_ff == cnt_ff) begin
               state_in = ST_SP_EMIT;
            end else if (marks_ff[j_ff[IW-1:0]]) begin
               j_in = j_ff + ONE;
            end else begin
               sm_raddr = j_ff[IW-1:0];
               state_in = ST_SP_GETB;
            end
         end
         ST_SP_GETB: begin
            iou_start = 1'b1;
            state_in = ST_SP_WAIT;
         end
         ST_SP_WAIT: begin
            if (iou_res.done) begin
               if (iou_res.hit) begin
                  marks_in[j_ff[IW-1:0]] = 1'b1;
               end else begin
                  any_in = 1'b1;
               end
               j_in = j_ff + ONE;
               state_in = ST_SP_RDB;
            end
         end
         ST_SP_EMIT: begin
            // last survivor when nothing ranked below it is left standing
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{out_left: a_ff.left, out_top: a_ff.top,
                          out_right: a_ff.right, out_bottom: a_ff.bottom,
                          out_score: a_ff.score, box_valid: 1'b1,
                          overflowed: ovf_ff, last_result: !any_ff};
               i_in = i_ff + ONE;
               state_in = ST_SP_RDA;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.overflowed = ovf_ff;
               rsp_in.last_result = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cnt_in = '0;
            ovf_in = 1'b0;
            marks_in = '0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         marks_ff <= '0;
         rsp_valid_ff <= 1'b0;
         score_lim_ff <= SCORE_LIMIT_RST;
         overlap_lim_ff <= OVERLAP_LIMIT_RST;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         marks_ff <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == CSR_SCORE_LIMIT) begin
            score_lim_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_OVERLAP_LIMIT) begin
            overlap_lim_ff <= csr_data;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      pos_ff <= pos_in;
      any_ff <= any_in;
      cur_ff <= cur_in;
      a_ff <= a_in;
      rsp_ff <= rsp_in;
   end

   // Arrival-order box memory
   always_ff @(posedge clock) begin
      if (bm_we) begin
         box_mem[cnt_ff[IW-1:0]] <= new_box;
      end
      bm_rdata_ff <= box_mem[bm_raddr];
   end

   // Rank-order box memory
   always_ff @(posedge clock) begin
      if (sm_we) begin
         sort_mem[pos_ff] <= cur_ff;
      end
      sm_rdata_ff <= sort_mem[sm_raddr];
   end

endmodule

// ===== test/tb_box_score_filter_nms.sv =====
`timescale 1ns / 100ps

// Scoreboard: frame predictor plus queue of expected surviving boxes
class nms_scoreboard;
   logic [15:0] score_lim;
   logic [15:0] overlap_lim;
   bsf_pkg::box_type frame_boxes[$];
   bit frame_ovf;
   bsf_pkg::rsp_type pending_boxes[$];
   int errors;

   function new();
      score_lim = bsf_pkg::SCORE_LIMIT_RST;
      overlap_lim = bsf_pkg::OVERLAP_LIMIT_RST;
      frame_ovf = 0;
      errors = 0;
   endfunction

   function longint unsigned span(input logic [15:0] lo, input logic [15:0] hi);
      span = (hi > lo) ? longint'(hi - lo) : 0;
   endfunction

   function bit too_close(input bsf_pkg::box_type a, input bsf_pkg::box_type b);
      longint unsigned inter, uni, aa, ab;
      logic [15:0] l, t, r, d;
      l = (a.left > b.left) ? a.left : b.left;
      t = (a.top > b.top) ? a.top : b.top;
      r = (a.right < b.right) ? a.right : b.right;
      d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
      inter = span(l, r) * span(t, d);
      aa = span(a.left, a.right) * span(a.top, a.bottom);
      ab = span(b.left, b.right) * span(b.top, b.bottom);
      uni = aa + ab - inter;
      if (uni == 0) return 0;
      too_close = (inter << 16) > longint'(overlap_lim) * uni;
   endfunction

   // Filter, store, and on the final request rank and suppress
   function void note_request(input bsf_pkg::req_type rq);
      bsf_pkg::box_type b, ranked[$];
      bsf_pkg::rsp_type rs;
      bit dead[$];
      int j, n;
      if (rq.box_score >= score_lim) begin
         if (frame_boxes.size() < 64) begin
            b = '{rq.left_edge, rq.top_edge, rq.right_edge, rq.bottom_edge, rq.box_score};
            frame_boxes = {frame_boxes, b};
         end else begin
            frame_ovf = 1;
         end
      end
      if (!rq.final_box) return;
      // stable sort, highest score first
      foreach (frame_boxes[i]) begin
         j = ranked.size();
         while (j > 0 && ranked[j-1].score < frame_boxes[i].score) j--;
         ranked.insert(j, frame_boxes[i]);
         dead = {dead, 1'b0};
      end
      n = 0;
      foreach (ranked[i]) begin
         if (dead[i]) continue;
         for (int k = i + 1; k < ranked.size(); k++)
            if (!dead[k] && too_close(ranked[i], ranked[k])) dead[k] = 1;
         rs = '{ranked[i].left, ranked[i].top, ranked[i].right, ranked[i].bottom,
                ranked[i].score, 1'b1, frame_ovf, 1'b0};
         pending_boxes = {pending_boxes, rs};
         n++;
      end
      if (n == 0) begin
         rs = '0;
         rs.overflowed = frame_ovf;
         pending_boxes = {pending_boxes, rs};
      end
      // flag the frame's final response
      rs = pending_boxes.pop_back();
      rs.last_result = 1'b1;
      pending_boxes = {pending_boxes, rs};
      frame_boxes.delete();
      frame_ovf = 0;
   endfunction

   function void check_result(input bsf_pkg::rsp_type got);
      bsf_pkg::rsp_type exp_r;
      if (pending_boxes.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
         return;
      end
      exp_r = pending_boxes.pop_front();
      if (got !== exp_r) begin
         $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
         errors++;
      end
   endfunction
endclass

module tb_box_score_filter_nms;
   import bsf_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_data;

   nms_scoreboard board;
   int cycle_count;
   int frame_len;

   box_score_filter_nms u_top (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Global watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response side with random stalls
   initial begin
      int w;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (rsp_valid && rsp_ready || !rsp_ready) begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (cycle_count % 2000 < 500) w = 0;
            if (w == 0) rsp_ready <= 1;
            else begin
               rsp_ready <= 0;
               repeat (w) @(posedge clock);
               rsp_ready <= 1;
            end
         end
      end
   end

   // Valid stays up between back-to-back requests; it drops while idling
   task automatic send_box(input req_type rq);
      int w;
      w = (cycle_count % 3000 < 800) ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      board.note_request(rq);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCORE_LIMIT) board.score_lim = v;
      else board.overlap_lim = v;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_boxes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type rand_box(input bit fin, input bit near);
      req_type rq;
      logic [15:0] x, y;
      x = near ? 16'($urandom_range(100, 400)) : 16'($urandom);
      y = near ? 16'($urandom_range(100, 400)) : 16'($urandom);
      rq.left_edge = x;
      rq.top_edge = y;
      rq.right_edge = near ? x + 16'($urandom_range(0, 200)) : 16'($urandom);
      rq.bottom_edge = near ? y + 16'($urandom_range(0, 200)) : 16'($urandom);
      rq.box_score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(45000, 46000))
                                                 : 16'($urandom);
      rq.final_box = fin;
      return rq;
   endfunction

   initial begin
      req_type rq;
      board = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = CSR_SCORE_LIMIT;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, drops, reversed edges, equal scores, empty frame
      send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
      send_box('{16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
      send_box('{16'h10, 16'h10, 16'h100, 16'h100, 16'hB333, 1'b0});
      send_box('{16'h100, 16'h100, 16'h10, 16'h10, 16'hC000, 1'b0});
      send_box('{16'h20, 16'h20, 16'h110, 16'h110, 16'hB333, 1'b0});
      send_box('{16'h5, 16'h5, 16'h50, 16'h50, 16'h0, 1'b1});
      drain();
      send_box('{16'h1, 16'h2, 16'h3, 16'h4, 16'hB332, 1'b1});
      drain();
      // Overflow: 66 kept boxes, zero threshold
      write_reg(CSR_SCORE_LIMIT, 16'h0);
      write_reg(CSR_OVERLAP_LIMIT, 16'hFFFF);
      for (int i = 0; i < 66; i++) begin
         rq = rand_box(i == 65, 0);
         send_box(rq);
      end
      drain();
      write_reg(CSR_SCORE_LIMIT, 16'hFFFF);
      write_reg(CSR_OVERLAP_LIMIT, 16'h0);
      send_box('{16'h0, 16'h0, 16'h8, 16'h8, 16'hFFFF, 1'b0});
      send_box('{16'h4, 16'h4, 16'hC, 16'hC, 16'hFFFF, 1'b1});
      drain();

      // Random frames under several settings
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_SCORE_LIMIT, p == 0 ? SCORE_LIMIT_RST : 16'($urandom_range(0, 50000)));
         write_reg(CSR_OVERLAP_LIMIT, p == 0 ? OVERLAP_LIMIT_RST : 16'($urandom));
         for (int f = 0; f < 7; f++) begin
            frame_len = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 30)
                                                    : $urandom_range(1, 10);
            for (int i = 0; i < frame_len; i++) begin
               rq = rand_box(i == frame_len - 1, $urandom_range(0, 3) != 0);
               send_box(rq);
            end
         end
         drain();
      end

      drain();
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
